FILE: rtl/scalar_kalman_filter_defines.svh
// Assertion macros shared by the RTL.
`ifndef SCALAR_KALMAN_FILTER_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_DEFINES_SVH

`ifndef ASSERT_OFF
// Antecedent holds -> consequent holds in the same cycle.
`define SKF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Antecedent holds -> consequent holds in the next cycle.
`define SKF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SKF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SKF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/skf_pkg.sv
package skf_pkg;

    localparam int SampleBitsDef = 16;
    localparam int FracBitsDef   = 16;

    localparam int GainFrac   = 16;
    localparam int GainW      = GainFrac + 1;
    localparam int WordW      = 32;
    localparam int PcW        = 4;
    localparam int OpW        = 4;
    localparam int CondW      = 2;

    localparam logic [WordW-1:0] ProcNoiseRst = 32'd655;
    localparam logic [WordW-1:0] MeasNoiseRst = 32'd65536;
    localparam logic [GainW-1:0] GainOne      = 17'h10000;

    // register indexes
    localparam logic CFG_PROC_NOISE = 1'b0;
    localparam logic CFG_MEAS_NOISE = 1'b1;

    // datapath operations
    localparam logic [OpW-1:0] OP_IDLE  = 4'd0;
    localparam logic [OpW-1:0] OP_PRED  = 4'd1;
    localparam logic [OpW-1:0] OP_DINIT = 4'd2;
    localparam logic [OpW-1:0] OP_DSTEP = 4'd3;
    localparam logic [OpW-1:0] OP_GAIN  = 4'd4;
    localparam logic [OpW-1:0] OP_MULX  = 4'd5;
    localparam logic [OpW-1:0] OP_UPDX  = 4'd6;
    localparam logic [OpW-1:0] OP_MULP  = 4'd7;
    localparam logic [OpW-1:0] OP_UPDP  = 4'd8;
    localparam logic [OpW-1:0] OP_OUT   = 4'd9;

    // sequencing conditions
    localparam logic [CondW-1:0] C_NEXT     = 2'd0; // pc + 1
    localparam logic [CondW-1:0] C_WAIT_IN  = 2'd1; // hold until a beat is taken
    localparam logic [CondW-1:0] C_LOOP     = 2'd2; // jump while count nonzero
    localparam logic [CondW-1:0] C_WAIT_OUT = 2'd3; // hold until result slot free

    // program addresses
    localparam logic [PcW-1:0] PC_IDLE  = 4'd0;
    localparam logic [PcW-1:0] PC_PRED  = 4'd1;
    localparam logic [PcW-1:0] PC_DINIT = 4'd2;
    localparam logic [PcW-1:0] PC_DSTEP = 4'd3;
    localparam logic [PcW-1:0] PC_GAIN  = 4'd4;
    localparam logic [PcW-1:0] PC_MULX  = 4'd5;
    localparam logic [PcW-1:0] PC_UPDX  = 4'd6;
    localparam logic [PcW-1:0] PC_MULP  = 4'd7;
    localparam logic [PcW-1:0] PC_UPDP  = 4'd8;
    localparam logic [PcW-1:0] PC_OUT   = 4'd9;

    typedef struct packed {
        logic [OpW-1:0]   op;
        logic [CondW-1:0] cond;
        logic [PcW-1:0]   tgt;
    } t_uword;

    // control store
    function automatic t_uword uw_rom(input logic [PcW-1:0] pc);
        t_uword w;
        case (pc)
            PC_IDLE:  w = '{op: OP_IDLE,  cond: C_WAIT_IN,  tgt: PC_PRED};
            PC_PRED:  w = '{op: OP_PRED,  cond: C_NEXT,     tgt: PC_DINIT};
            PC_DINIT: w = '{op: OP_DINIT, cond: C_NEXT,     tgt: PC_DSTEP};
            PC_DSTEP: w = '{op: OP_DSTEP, cond: C_LOOP,     tgt: PC_DSTEP};
            PC_GAIN:  w = '{op: OP_GAIN,  cond: C_NEXT,     tgt: PC_MULX};
            PC_MULX:  w = '{op: OP_MULX,  cond: C_NEXT,     tgt: PC_UPDX};
            PC_UPDX:  w = '{op: OP_UPDX,  cond: C_NEXT,     tgt: PC_MULP};
            PC_MULP:  w = '{op: OP_MULP,  cond: C_NEXT,     tgt: PC_UPDP};
            PC_UPDP:  w = '{op: OP_UPDP,  cond: C_NEXT,     tgt: PC_OUT};
            PC_OUT:   w = '{op: OP_OUT,   cond: C_WAIT_OUT, tgt: PC_IDLE};
            default:  w = '{op: OP_IDLE,  cond: C_WAIT_OUT, tgt: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/scalar_kalman_filter.sv
// Scalar (1-D) Kalman filter over unsigned ADC samples, fixed point.
// Input channel: i_in_valid / o_in_stall with i_sample. A beat is taken when
//   valid is high and stall is low; stall is low only while the sequencer
//   sits at its idle step.
// Output channel: o_out_valid / i_out_stall with o_estimate (Q16.16) and
//   o_gain (Q1.16, 0x10000 = one). One result per sample.
// Config: i_cfg_we / i_cfg_idx / i_cfg_data, index 0 = Q, 1 = R. Write only
//   while the filter is idle.
// Steps after an input beat: predict, divider setup, 17 restoring-divide
//   steps for the gain, then gain latch, two shared-multiplier passes with
//   their updates, and the output step.
// One sample at a time; the bit-serial gain divider takes most of each pass.
// The output register frees the sequencer; the next beat can be taken while
//   a result waits. If a second result finishes before the first is taken,
//   the sequencer holds at its output step until the slot frees.
// Reset (synchronous, active low): estimate and covariance clear to zero,
//   Q = 655, R = 65536, no result pending, sequencer at idle.
// Receiver stall: o_estimate and o_gain hold; nothing is lost.
`include "scalar_kalman_filter_defines.svh"

module scalar_kalman_filter
    import skf_pkg::*;
#(
    parameter int SAMPLE_BITS = SampleBitsDef,
    parameter int FRAC_BITS   = FracBitsDef
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    // output channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [WordW-1:0]       o_estimate,
    output logic [GainW-1:0]       o_gain,
    // config write port
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [WordW-1:0]       i_cfg_data
);

    // target width and magnitude width (covers both the estimate and p)
    localparam int TgtW = SAMPLE_BITS + FRAC_BITS;
    localparam int MagW = (TgtW > WordW) ? TgtW : WordW;
    localparam int ProdW = MagW + GainW;
    localparam int CntW = $clog2(GainFrac + 1);
    localparam logic [CntW-1:0] DivLast = CntW'(GainFrac);
    localparam logic [ProdW:0]  RoundHalf = (ProdW+1)'(1) << (GainFrac - 1);
    localparam logic [MagW:0]   WordMaxUp = (MagW+1)'({WordW{1'b1}});
    localparam logic [MagW-1:0] WordMaxM  = MagW'({WordW{1'b1}});

    // sequencer
    logic [PcW-1:0]  r_pc, n_pc;
    logic [CntW-1:0] r_cnt;
    t_uword          uw;

    // config and state
    logic [WordW-1:0] r_qn, r_rn;
    logic [WordW-1:0] r_x, r_cov;

    // datapath
    logic [SAMPLE_BITS-1:0] r_smp;
    logic [WordW-1:0]       r_p;
    logic [WordW:0]         r_den;
    logic [WordW+1:0]       r_rem;
    logic [GainW-1:0]       r_q;
    logic                   r_dz;
    logic [GainW-1:0]       r_g;
    logic [MagW-1:0]        r_mag;
    logic                   r_neg;
    logic [ProdW-1:0]       r_prod;
    logic [WordW-1:0]       r_nx;

    // output slot
    logic             r_out_valid;
    logic [WordW-1:0] r_est;
    logic [GainW-1:0] r_gout;

    logic in_acc, out_free;

    assign uw       = uw_rom(r_pc);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_pc != PC_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_estimate  = r_est;
    assign o_gain      = r_gout;

    // next program step
    always_comb begin
        case (uw.cond)
            C_NEXT:     n_pc = r_pc + PcW'(1);
            C_WAIT_IN:  n_pc = in_acc ? uw.tgt : r_pc;
            C_LOOP:     n_pc = (r_cnt != '0) ? uw.tgt : r_pc + PcW'(1);
            C_WAIT_OUT: n_pc = out_free ? uw.tgt : r_pc;
            default:    n_pc = PC_IDLE;
        endcase
    end

    // predict: saturating p + Q
    logic [WordW:0]   psum;
    logic [WordW-1:0] p_sat;
    assign psum  = {1'b0, r_cov} + {1'b0, r_qn};
    assign p_sat = psum[WordW] ? {WordW{1'b1}} : psum[WordW-1:0];

    // one restoring-divide step; remainder stays below twice the denominator
    logic [WordW+2:0] dtr;
    logic             qbit;
    logic [WordW+1:0] rsel;
    assign dtr  = {1'b0, r_rem} - {2'b00, r_den};
    assign qbit = !dtr[WordW+2];
    assign rsel = qbit ? dtr[WordW+1:0] : r_rem;

    // remainder bound for the divider check; a zero denominator is exempt
    logic rem_ok;
    assign rem_ok = r_dz || (r_rem < {r_den, 1'b0});

    // innovation magnitude and sign
    logic [MagW-1:0] tgt_w, x_w;
    assign tgt_w = MagW'(r_smp) << FRAC_BITS;
    assign x_w   = MagW'(r_x);

    // shared multiplier: |d| * g, then (1 - g) * p
    logic [MagW-1:0]  mul_a;
    logic [GainW-1:0] mul_b;
    logic [ProdW-1:0] prod_c;
    always_comb begin
        if (uw.op == OP_MULP) begin
            mul_a = MagW'(r_p);
            mul_b = GainOne - r_g;
        end else begin
            mul_a = r_mag;
            mul_b = r_g;
        end
    end
    assign prod_c = ProdW'(mul_a) * ProdW'(mul_b);

    // rounding shift of the product
    logic [ProdW:0]  rnd;
    logic [MagW-1:0] stp;
    assign rnd = {1'b0, r_prod} + RoundHalf;
    assign stp = rnd[GainFrac +: MagW];

    // estimate update
    logic [MagW:0]    up;
    logic [MagW-1:0]  dn;
    logic [WordW-1:0] nx_c;
    assign up = {1'b0, x_w} + {1'b0, stp};
    assign dn = x_w - stp;
    always_comb begin
        if (!r_neg) begin
            nx_c = (up > WordMaxUp) ? {WordW{1'b1}} : up[WordW-1:0];
        end else begin
            nx_c = (stp >= x_w) ? '0 : dn[WordW-1:0];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_x         <= '0;
            r_cov       <= '0;
            r_qn        <= ProcNoiseRst;
            r_rn        <= MeasNoiseRst;
        end else begin
            r_pc <= n_pc;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PROC_NOISE: r_qn <= i_cfg_data;
                    CFG_MEAS_NOISE: r_rn <= i_cfg_data;
                    default: ;
                endcase
            end
            if (uw.op == OP_DINIT) begin
                r_cnt <= DivLast;
            end else if (uw.op == OP_DSTEP && r_cnt != '0) begin
                r_cnt <= r_cnt - CntW'(1);
            end
            if (uw.op == OP_UPDX) begin
                r_x <= nx_c;
            end
            if (uw.op == OP_UPDP) begin
                r_cov <= (stp > WordMaxM) ? {WordW{1'b1}} : stp[WordW-1:0];
            end
            if (uw.op == OP_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (uw.op)
            OP_IDLE: begin
                if (in_acc) r_smp <= i_sample;
            end
            OP_PRED: begin
                r_p <= p_sat;
            end
            OP_DINIT: begin
                r_den <= {1'b0, r_p} + {1'b0, r_rn};
                r_rem <= {2'b00, r_p};
                r_q   <= '0;
                r_dz  <= (r_p == '0) && (r_rn == '0);
            end
            OP_DSTEP: begin
                r_q   <= {r_q[GainW-2:0], qbit};
                r_rem <= {rsel[WordW:0], 1'b0};
            end
            OP_GAIN: begin
                r_g   <= r_dz ? '0 : r_q;
                r_neg <= (tgt_w < x_w);
                r_mag <= (tgt_w >= x_w) ? (tgt_w - x_w) : (x_w - tgt_w);
            end
            OP_MULX, OP_MULP: begin
                r_prod <= prod_c;
            end
            OP_UPDX: begin
                r_nx <= nx_c;
            end
            OP_OUT: begin
                if (out_free) begin
                    r_est  <= r_nx;
                    r_gout <= r_g;
                end
            end
            default: ;
        endcase
    end

    // checks
    `SKF_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, in_acc, r_pc == PC_PRED)
    `SKF_ASSERT_IMP(a_rem_bound, i_clk, i_rst_n, r_pc == PC_DSTEP && r_cnt != DivLast, rem_ok)
    `SKF_ASSERT_IMP(a_gain_range, i_clk, i_rst_n, o_out_valid, o_gain <= GainOne)

endmodule

FILE: verif/scalar_kalman_filter_test.sv
module scalar_kalman_filter_test
    import skf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Fixed-point helpers used by the filter math below.
    localparam logic [63:0] WordMax   = 64'hFFFF_FFFF;
    localparam logic [63:0] RoundHalf = 64'd1 << (GainFrac - 1);

    // Nothing accepted on either channel for this long means the block hung.
    // The longest legal quiet spell is the receiver hold-off plus one item
    // plus a sender gap, so this leaves a wide margin.
    localparam int StallLimit  = 5000;
    localparam int HoldOffLen  = 300;
    localparam int HoldOffAt   = 600;   // results seen before the hold-off starts
    localparam int SettleWait  = 40;    // outlasts one item's pass through the sequencer
    localparam int RandPhases  = 8;
    localparam int PhaseItems  = 250;
    localparam int CalmPhase   = 2;     // random phase with no random gaps or stalls

    typedef struct {
        logic [WordW-1:0] estimate;
        logic [GainW-1:0] gain;
    } t_kalman_result;

    // Tracks the filter state alongside the block and holds the results
    // that are owed by the output channel, oldest first.
    class kalman_scoreboard;
        logic [WordW-1:0] q_noise = ProcNoiseRst;
        logic [WordW-1:0] r_noise = MeasNoiseRst;
        logic [WordW-1:0] est     = '0;
        logic [WordW-1:0] cov     = '0;
        t_kalman_result   owed[$];
        int               checked = 0;
        int               errors  = 0;

        function void set_reg(input logic idx, input logic [WordW-1:0] value);
            if (idx == CFG_PROC_NOISE) begin
                q_noise = value;
            end else begin
                r_noise = value;
            end
        endfunction

        // One filter step: predict, gain, estimate update, covariance update.
        function void note_sample(input logic [SampleBitsDef-1:0] s);
            logic [63:0] target, x, p, den, g, step, nx, np;
            t_kalman_result res;
            target = 64'(s) << FracBitsDef;
            x = 64'(est);
            p = 64'(cov) + 64'(q_noise);
            if (p > WordMax) begin
                p = WordMax;
            end
            den = p + 64'(r_noise);
            g = (den == 64'd0) ? 64'd0 : (p << GainFrac) / den;
            // rounding is on the magnitude, so handle the two signs apart
            if (target >= x) begin
                step = ((target - x) * g + RoundHalf) >> GainFrac;
                nx = x + step;
            end else begin
                step = ((x - target) * g + RoundHalf) >> GainFrac;
                nx = (step >= x) ? 64'd0 : x - step;
            end
            if (nx > WordMax) begin
                nx = WordMax;
            end
            np = ((64'(GainOne) - g) * p + RoundHalf) >> GainFrac;
            if (np > WordMax) begin
                np = WordMax;
            end
            est = nx[WordW-1:0];
            cov = np[WordW-1:0];
            res.estimate = nx[WordW-1:0];
            res.gain = g[GainW-1:0];
            owed.push_back(res);
        endfunction

        function void check_result(input logic [WordW-1:0] estimate,
                                   input logic [GainW-1:0] gain);
            t_kalman_result exp_res;
            checked++;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result: expected none, got estimate %h gain %h",
                         $time, estimate, gain);
                errors++;
                return;
            end
            exp_res = owed.pop_front();
            if (estimate !== exp_res.estimate) begin
                $display("%0t: estimate mismatch: expected %h, got %h",
                         $time, exp_res.estimate, estimate);
                errors++;
            end
            if (gain !== exp_res.gain) begin
                $display("%0t: gain mismatch: expected %h, got %h",
                         $time, exp_res.gain, gain);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [SampleBitsDef-1:0] i_sample;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [WordW-1:0]         o_estimate;
    logic [GainW-1:0]         o_gain;
    logic                     i_cfg_we;
    logic                     i_cfg_idx;
    logic [WordW-1:0]         i_cfg_data;

    kalman_scoreboard sb = new;

    // Both sides skip random idling while this is set.
    bit calm = 1'b0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;

    scalar_kalman_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_estimate  (o_estimate),
        .o_gain      (o_gain),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Output monitor. Runs in the active region of the edge, so it sees the
    // values the block presented just before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_estimate, o_gain);
        end
    end

    // Receiver stall: random back-pressure, plus one long hold-off partway
    // through so the result slot and the sequencer both fill and the input
    // channel stalls while the sender keeps offering beats.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && sb.checked >= HoldOffAt) begin
            hold_done = 1'b1;
            hold_left = HoldOffLen - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(0, 99) < 27);
        end
    end

    // Watchdog: counts cycles in which no beat moves on either channel.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= StallLimit) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Offers one sample and returns at the edge where it is taken. Valid is
    // left high; the caller either offers the next beat or lowers it in the
    // same time step.
    task automatic send_sample(input logic [SampleBitsDef-1:0] s);
        i_in_valid <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sb.note_sample(s);
    endtask

    // Random sender gap, roughly 27 beats in a hundred.
    task automatic maybe_idle();
        if (!calm && $urandom_range(0, 99) < 27) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Stop offering, let every owed result come back, then give the block
    // time to settle before any register write.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.owed.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SettleWait) @(posedge i_clk);
    endtask

    // Writes Q then R on back-to-back edges; only called after drain.
    task automatic write_noise(input logic [WordW-1:0] q, input logic [WordW-1:0] r);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_PROC_NOISE;
        i_cfg_data <= q;
        @(posedge i_clk);
        sb.set_reg(CFG_PROC_NOISE, q);
        i_cfg_idx <= CFG_MEAS_NOISE;
        i_cfg_data <= r;
        @(posedge i_clk);
        sb.set_reg(CFG_MEAS_NOISE, r);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [WordW-1:0] pick_noise();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(1, 4096);
            3:       return $urandom_range(4096, 32'h0010_0000);
            default: return $urandom();
        endcase
    endfunction

    // Mostly full-range samples, with rails and values close to the current
    // estimate mixed in so the small-difference rounding gets exercised.
    function automatic logic [SampleBitsDef-1:0] pick_sample();
        int pick;
        int near;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            return '0;
        end else if (pick < 16) begin
            return '1;
        end else if (pick < 32) begin
            near = int'(sb.est >> FracBitsDef) + int'($urandom_range(0, 8)) - 4;
            if (near < 0) begin
                near = 0;
            end else if (near > 65535) begin
                near = 65535;
            end
            return near[SampleBitsDef-1:0];
        end
        return SampleBitsDef'($urandom());
    endfunction

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_sample <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_PROC_NOISE;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset noise settings: rails, single bits, alternating patterns.
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'hFFFF);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        send_sample(16'h0000);
        drain();

        // Q = R = 0: the first step still has covariance left so the gain is
        // one and the covariance collapses; after that the denominator is
        // zero and the gain stays zero.
        write_noise('0, '0);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h1234);
        drain();

        // Max Q and R: the predicted covariance saturates.
        write_noise('1, '1);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        drain();

        // No measurement noise: gain of one, estimate jumps to the sample.
        write_noise(32'd1, '0);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h0001);
        drain();

        // Huge R against no process noise: the gain comes out as zero.
        write_noise('0, '1);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        drain();

        // Random noise settings per phase, one phase run with no random idling.
        for (int ph = 0; ph < RandPhases; ph++) begin
            write_noise(pick_noise(), pick_noise());
            calm = (ph == CalmPhase);
            for (int n = 0; n < PhaseItems; n++) begin
                maybe_idle();
                send_sample(pick_sample());
            end
            drain();
            calm = 1'b0;
        end

        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
